>>> design/group_timed_light_off_timer_unit_macros.svh
// ----------------------------------------------------------------------------
// group timed light off timer: assertion macros
// concurrent checks on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef GROUP_TIMED_LIGHT_OFF_TIMER_UNIT_MACROS_SVH
`define GROUP_TIMED_LIGHT_OFF_TIMER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define GTLOT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`define GTLOT_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`else

`define GTLOT_ASSERT_NEXT(label, ante, cons, msg)

`define GTLOT_ASSERT_NEVER(label, cond, msg)

`endif

`endif

>>> design/gtlot_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtlot_pkg
// shared types and constants of the group timed light off timer
// ----------------------------------------------------------------------------
package gtlot_pkg;

    localparam int OP_W     = 3;
    localparam int MASK_W   = 16;
    localparam int INDEX_W  = 4;
    localparam int DELAY_W  = 16;
    localparam int REPEAT_W = 8;
    localparam int MODE_W   = 2;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam logic [OP_W-1:0] OP_START   = 3'd0;
    localparam logic [OP_W-1:0] OP_TICK    = 3'd1;
    localparam logic [OP_W-1:0] OP_INHIBIT = 3'd2;
    localparam logic [OP_W-1:0] OP_RELOAD  = 3'd3;
    localparam logic [OP_W-1:0] OP_INIT    = 3'd4;

    localparam logic REG_REPEAT_PERIOD = 1'b0;
    localparam logic REG_OPERATIVE     = 1'b1;

    localparam logic [REPEAT_W-1:0] REPEAT_PERIOD_RST = 8'd30;
    localparam logic [MASK_W-1:0]   OPERATIVE_RST     = 16'd0;

    typedef enum logic [MODE_W-1:0] {
        MODE_OFF  = 2'd0,
        MODE_RUN  = 2'd1,
        MODE_STOP = 2'd2
    } mode_t;

    typedef struct packed {
        logic start;
        logic step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic last;
    } status_t;

endpackage

>>> design/gtlot_item_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtlot_item_if
// input item channel: valid/ready handshake with item payload
// ----------------------------------------------------------------------------
interface gtlot_item_if;
    logic                             valid;
    logic                             ready;
    logic [gtlot_pkg::OP_W-1:0]       op;
    logic [gtlot_pkg::MASK_W-1:0]     group_mask;
    logic [gtlot_pkg::INDEX_W-1:0]    group_index;
    logic [gtlot_pkg::DELAY_W-1:0]    delay_value;
    logic [gtlot_pkg::MASK_W-1:0]     presence_mask;
    logic [gtlot_pkg::MASK_W-1:0]     regulator_active_mask;

    modport source (
        output valid, op, group_mask, group_index, delay_value, presence_mask,
               regulator_active_mask,
        input  ready
    );

    modport sink (
        input  valid, op, group_mask, group_index, delay_value, presence_mask,
               regulator_active_mask,
        output ready
    );
endinterface

>>> design/gtlot_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtlot_result_if
// result channel: valid/ready handshake with result payload
// ----------------------------------------------------------------------------
interface gtlot_result_if;
    logic                             valid;
    logic                             ready;
    logic [gtlot_pkg::MASK_W-1:0]     on_mask;
    logic [gtlot_pkg::MASK_W-1:0]     off_mask;
    logic [gtlot_pkg::MASK_W-1:0]     refresh_mask;
    logic [gtlot_pkg::MODE_W-1:0]     query_mode;
    logic [gtlot_pkg::DELAY_W-1:0]    query_delay;
    logic [gtlot_pkg::REPEAT_W-1:0]   query_repeat;
    logic                             query_inhibited;

    modport source (
        output valid, on_mask, off_mask, refresh_mask, query_mode, query_delay,
               query_repeat, query_inhibited,
        input  ready
    );

    modport sink (
        input  valid, on_mask, off_mask, refresh_mask, query_mode, query_delay,
               query_repeat, query_inhibited,
        output ready
    );
endinterface

>>> design/gtlot_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtlot_cfg
// apb configuration registers: repeat period and operative groups
// ----------------------------------------------------------------------------
module gtlot_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [gtlot_pkg::ADDR_W-1:0]      paddr,
    input  logic [gtlot_pkg::DATA_W-1:0]      pwdata,
    output logic [gtlot_pkg::DATA_W-1:0]      prdata,
    output logic                              pready,
    output logic [gtlot_pkg::REPEAT_W-1:0]    repeat_period,
    output logic [gtlot_pkg::MASK_W-1:0]      operative_groups
);

    logic [gtlot_pkg::REPEAT_W-1:0] period_reg;
    logic [gtlot_pkg::REPEAT_W-1:0] period_next;
    logic [gtlot_pkg::MASK_W-1:0]   operative_reg;
    logic [gtlot_pkg::MASK_W-1:0]   operative_next;
    logic                           wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        period_next    = period_reg;
        operative_next = operative_reg;
        if (wr_en)
        begin
            case (paddr[2])
                gtlot_pkg::REG_REPEAT_PERIOD: period_next    = pwdata[gtlot_pkg::REPEAT_W-1:0];
                gtlot_pkg::REG_OPERATIVE:     operative_next = pwdata[gtlot_pkg::MASK_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg    <= gtlot_pkg::REPEAT_PERIOD_RST;
            operative_reg <= gtlot_pkg::OPERATIVE_RST;
        end
        else
        begin
            period_reg    <= period_next;
            operative_reg <= operative_next;
        end
    end

    always_comb
    begin
        case (paddr[2])
            gtlot_pkg::REG_REPEAT_PERIOD:
                prdata = gtlot_pkg::DATA_W'(period_reg);
            gtlot_pkg::REG_OPERATIVE:
                prdata = gtlot_pkg::DATA_W'(operative_reg);
            default:
                prdata = '0;
        endcase
    end

    assign repeat_period    = period_reg;
    assign operative_groups = operative_reg;

endmodule

>>> design/gtlot_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtlot_ctrl
// controller: accepts a transaction, sweeps all groups, hands off the result
// ----------------------------------------------------------------------------
module gtlot_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  gtlot_pkg::status_t  status,
    output gtlot_pkg::cmd_t     cmd
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SWEEP = 3'b010,
        S_FIN   = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_SWEEP;
                end
            end
            S_SWEEP:
            begin
                cmd.step = 1'b1;
                if (status.last)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> design/gtlot_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtlot_dp
// datapath: per-group state, one group updated per cycle, result registers
// ----------------------------------------------------------------------------
module gtlot_dp #(
    parameter int GROUPS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  gtlot_pkg::cmd_t                   cmd,
    output gtlot_pkg::status_t                status,
    input  logic [gtlot_pkg::OP_W-1:0]        op,
    input  logic [gtlot_pkg::MASK_W-1:0]      group_mask,
    input  logic [gtlot_pkg::INDEX_W-1:0]     group_index,
    input  logic [gtlot_pkg::DELAY_W-1:0]     delay_value,
    input  logic [gtlot_pkg::MASK_W-1:0]      presence_mask,
    input  logic [gtlot_pkg::MASK_W-1:0]      regulator_active_mask,
    input  logic [gtlot_pkg::REPEAT_W-1:0]    repeat_period,
    input  logic [gtlot_pkg::MASK_W-1:0]      operative_groups,
    output logic [gtlot_pkg::MASK_W-1:0]      on_mask,
    output logic [gtlot_pkg::MASK_W-1:0]      off_mask,
    output logic [gtlot_pkg::MASK_W-1:0]      refresh_mask,
    output logic [gtlot_pkg::MODE_W-1:0]      query_mode,
    output logic [gtlot_pkg::DELAY_W-1:0]     query_delay,
    output logic [gtlot_pkg::REPEAT_W-1:0]    query_repeat,
    output logic                              query_inhibited
);

    localparam int IDX_W = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(GROUPS - 1);

    // captured transaction
    logic [gtlot_pkg::OP_W-1:0]      op_reg;
    logic [GROUPS-1:0]               gmask_reg;
    logic [gtlot_pkg::INDEX_W-1:0]   gidx_reg;
    logic [gtlot_pkg::DELAY_W-1:0]   dval_reg;
    logic [GROUPS-1:0]               pres_reg;
    logic [GROUPS-1:0]               regact_reg;

    logic [IDX_W-1:0]                idx_reg;

    // per-group state
    gtlot_pkg::mode_t                mode_reg    [GROUPS];
    logic [gtlot_pkg::DELAY_W-1:0]   delay_reg   [GROUPS];
    logic [gtlot_pkg::REPEAT_W-1:0]  repeat_reg  [GROUPS];
    logic                            inhibit_reg [GROUPS];

    // accumulated masks and captured query
    logic [GROUPS-1:0]               on_acc_reg;
    logic [GROUPS-1:0]               off_acc_reg;
    logic [GROUPS-1:0]               ref_acc_reg;
    gtlot_pkg::mode_t                q_mode_reg;
    logic [gtlot_pkg::DELAY_W-1:0]   q_delay_reg;
    logic [gtlot_pkg::REPEAT_W-1:0]  q_repeat_reg;
    logic                            q_inh_reg;

    // result registers
    logic [gtlot_pkg::MASK_W-1:0]    on_out_reg;
    logic [gtlot_pkg::MASK_W-1:0]    off_out_reg;
    logic [gtlot_pkg::MASK_W-1:0]    ref_out_reg;
    logic [gtlot_pkg::MODE_W-1:0]    qmode_out_reg;
    logic [gtlot_pkg::DELAY_W-1:0]   qdelay_out_reg;
    logic [gtlot_pkg::REPEAT_W-1:0]  qrepeat_out_reg;
    logic                            qinh_out_reg;

    gtlot_pkg::mode_t                cur_mode;
    logic [gtlot_pkg::DELAY_W-1:0]   cur_delay;
    logic [gtlot_pkg::REPEAT_W-1:0]  cur_repeat;
    logic                            cur_inh;
    gtlot_pkg::mode_t                mode_next;
    logic [gtlot_pkg::DELAY_W-1:0]   delay_next;
    logic [gtlot_pkg::REPEAT_W-1:0]  repeat_next;
    logic                            inhibit_next;
    logic                            hit;
    logic                            off_req;
    logic                            on_bit;
    logic                            off_bit;
    logic                            ref_bit;

    assign status.last = (idx_reg == IDX_LAST);

    assign cur_mode   = mode_reg[idx_reg];
    assign cur_delay  = delay_reg[idx_reg];
    assign cur_repeat = repeat_reg[idx_reg];
    assign cur_inh    = inhibit_reg[idx_reg];
    assign hit        = (gtlot_pkg::INDEX_W'(idx_reg) == gidx_reg);

    always_comb
    begin
        mode_next    = cur_mode;
        delay_next   = cur_delay;
        repeat_next  = cur_repeat;
        inhibit_next = cur_inh;
        off_req      = 1'b0;
        on_bit       = 1'b0;
        off_bit      = 1'b0;
        ref_bit      = 1'b0;
        case (op_reg)
            gtlot_pkg::OP_START:
            begin
                if (gmask_reg[idx_reg] && cur_mode != gtlot_pkg::MODE_OFF)
                begin
                    on_bit       = 1'b1;
                    ref_bit      = regact_reg[idx_reg];
                    delay_next   = dval_reg;
                    inhibit_next = 1'b0;
                    mode_next    = gtlot_pkg::MODE_RUN;
                end
            end
            gtlot_pkg::OP_TICK:
            begin
                case (cur_mode)
                    gtlot_pkg::MODE_RUN:
                    begin
                        if (cur_delay != '0)
                            delay_next = cur_delay - gtlot_pkg::DELAY_W'(1);
                        else
                        begin
                            mode_next = gtlot_pkg::MODE_STOP;
                            off_req   = !cur_inh;
                        end
                    end
                    gtlot_pkg::MODE_STOP:
                    begin
                        if (cur_repeat != '0)
                            repeat_next = cur_repeat - gtlot_pkg::REPEAT_W'(1);
                        else
                        begin
                            off_req     = !cur_inh;
                            repeat_next = repeat_period;
                        end
                    end
                    default: ;
                endcase
            end
            gtlot_pkg::OP_INHIBIT:
            begin
                if (hit)
                    inhibit_next = 1'b1;
            end
            gtlot_pkg::OP_RELOAD:
            begin
                if (hit)
                    repeat_next = repeat_period;
            end
            gtlot_pkg::OP_INIT:
            begin
                mode_next    = operative_groups[idx_reg] ? gtlot_pkg::MODE_RUN
                                                         : gtlot_pkg::MODE_OFF;
                delay_next   = '0;
                repeat_next  = '0;
                inhibit_next = 1'b0;
            end
            default: ;
        endcase
        if (off_req)
        begin
            ref_bit = regact_reg[idx_reg];
            off_bit = !pres_reg[idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            for (int g = 0; g < GROUPS; g++)
            begin
                mode_reg[g]    <= gtlot_pkg::MODE_OFF;
                delay_reg[g]   <= '0;
                repeat_reg[g]  <= '0;
                inhibit_reg[g] <= 1'b0;
            end
        end
        else if (cmd.start)
            idx_reg <= '0;
        else if (cmd.step)
        begin
            mode_reg[idx_reg]    <= mode_next;
            delay_reg[idx_reg]   <= delay_next;
            repeat_reg[idx_reg]  <= repeat_next;
            inhibit_reg[idx_reg] <= inhibit_next;
            idx_reg              <= status.last ? '0 : idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            op_reg       <= op;
            gmask_reg    <= group_mask[GROUPS-1:0];
            gidx_reg     <= group_index;
            dval_reg     <= delay_value;
            pres_reg     <= presence_mask[GROUPS-1:0];
            regact_reg   <= regulator_active_mask[GROUPS-1:0];
            on_acc_reg   <= '0;
            off_acc_reg  <= '0;
            ref_acc_reg  <= '0;
            q_mode_reg   <= gtlot_pkg::MODE_OFF;
            q_delay_reg  <= '0;
            q_repeat_reg <= '0;
            q_inh_reg    <= 1'b0;
        end
        else if (cmd.step)
        begin
            on_acc_reg[idx_reg]  <= on_bit;
            off_acc_reg[idx_reg] <= off_bit;
            ref_acc_reg[idx_reg] <= ref_bit;
            if (hit)
            begin
                q_mode_reg   <= mode_next;
                q_delay_reg  <= delay_next;
                q_repeat_reg <= repeat_next;
                q_inh_reg    <= inhibit_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            on_out_reg      <= gtlot_pkg::MASK_W'(on_acc_reg);
            off_out_reg     <= gtlot_pkg::MASK_W'(off_acc_reg);
            ref_out_reg     <= gtlot_pkg::MASK_W'(ref_acc_reg);
            qmode_out_reg   <= q_mode_reg;
            qdelay_out_reg  <= q_delay_reg;
            qrepeat_out_reg <= q_repeat_reg;
            qinh_out_reg    <= q_inh_reg;
        end
    end

    assign on_mask         = on_out_reg;
    assign off_mask        = off_out_reg;
    assign refresh_mask    = ref_out_reg;
    assign query_mode      = qmode_out_reg;
    assign query_delay     = qdelay_out_reg;
    assign query_repeat    = qrepeat_out_reg;
    assign query_inhibited = qinh_out_reg;

endmodule

>>> design/group_timed_light_off_timer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// group_timed_light_off_timer_unit
// timed light off timer for up to GROUPS lighting groups
// ----------------------------------------------------------------------------
// in_ch carries one command transaction (start, tick, inhibit, reload, init)
// with its masks, group index and delay; out_ch returns exactly one result
// transaction per command: on/off/refresh masks and the state of the group
// named by group_index after the command.
// apb port: repeat_period at byte 0, operative_groups at byte 4; write only
// while no transaction is in flight.
// sequence: a transaction is taken in idle, then one group is visited per
// cycle in the sweep, then the finish state loads the result register once
// it is free; no new transaction is taken until the block is back in idle.
// reset clears all groups to not operative with zero counters and flags,
// loads repeat_period 30 and operative_groups 0, and drops out valid.
// a stalled receiver holds the result register; the block then finishes the
// sweep and waits before loading the next result, taking no new transaction.
// ----------------------------------------------------------------------------
`include "group_timed_light_off_timer_unit_macros.svh"

module group_timed_light_off_timer_unit #(
    parameter int GROUPS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    gtlot_item_if.sink                        in_ch,
    gtlot_result_if.source                    out_ch,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [gtlot_pkg::ADDR_W-1:0]      paddr,
    input  logic [gtlot_pkg::DATA_W-1:0]      pwdata,
    output logic [gtlot_pkg::DATA_W-1:0]      prdata,
    output logic                              pready
);

    gtlot_pkg::cmd_t                 ctrl_cmd;
    gtlot_pkg::status_t              dp_status;
    logic [gtlot_pkg::REPEAT_W-1:0]  repeat_period;
    logic [gtlot_pkg::MASK_W-1:0]    operative_groups;

    gtlot_cfg u_cfg (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .repeat_period    (repeat_period),
        .operative_groups (operative_groups)
    );

    gtlot_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (dp_status),
        .cmd       (ctrl_cmd)
    );

    gtlot_dp #(
        .GROUPS (GROUPS)
    ) u_dp (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cmd                   (ctrl_cmd),
        .status                (dp_status),
        .op                    (in_ch.op),
        .group_mask            (in_ch.group_mask),
        .group_index           (in_ch.group_index),
        .delay_value           (in_ch.delay_value),
        .presence_mask         (in_ch.presence_mask),
        .regulator_active_mask (in_ch.regulator_active_mask),
        .repeat_period         (repeat_period),
        .operative_groups      (operative_groups),
        .on_mask               (out_ch.on_mask),
        .off_mask              (out_ch.off_mask),
        .refresh_mask          (out_ch.refresh_mask),
        .query_mode            (out_ch.query_mode),
        .query_delay           (out_ch.query_delay),
        .query_repeat          (out_ch.query_repeat),
        .query_inhibited       (out_ch.query_inhibited)
    );

    `GTLOT_ASSERT_NEXT(a_accept_starts_sweep, in_ch.valid && in_ch.ready, ctrl_cmd.step,
        "sweep did not follow an accepted transaction")
    `GTLOT_ASSERT_NEVER(a_no_result_overwrite, ctrl_cmd.load_out && out_ch.valid && !out_ch.ready,
        "result register overwritten while stalled")
    `GTLOT_ASSERT_NEVER(a_no_accept_in_sweep, in_ch.ready && ctrl_cmd.step,
        "input ready during group sweep")

endmodule

>>> tb/sv/group_timed_light_off_timer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// group_timed_light_off_timer_unit_tb
// self-checking bench for the group timed light off timer
// ----------------------------------------------------------------------------
// a clocked driver feeds command transactions from a queue and predicts the
// on/off/refresh masks and group query of each one as it is accepted; a
// clocked monitor checks every result transaction in order. the apb registers
// are rewritten between phases while the block is drained, and both channel
// sides idle at random, including one long receiver hold-off.
// ----------------------------------------------------------------------------
module group_timed_light_off_timer_unit_tb;
    import gtlot_pkg::*;

    localparam int GROUPS = 16;
    localparam int MAX_REPORTS = 10;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_PER_SET = 160;
    localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_MID   = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [MASK_W-1:0]  group_mask;
        logic [INDEX_W-1:0] group_index;
        logic [DELAY_W-1:0] delay_value;
        logic [MASK_W-1:0]  presence_mask;
        logic [MASK_W-1:0]  regulator_active_mask;
    } light_cmd_t;

    typedef struct packed {
        logic [MASK_W-1:0]   on_mask;
        logic [MASK_W-1:0]   off_mask;
        logic [MASK_W-1:0]   refresh_mask;
        logic [MODE_W-1:0]   query_mode;
        logic [DELAY_W-1:0]  query_delay;
        logic [REPEAT_W-1:0] query_repeat;
        logic                query_inhibited;
    } light_order_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;

    gtlot_item_if   item_ch ();
    gtlot_result_if res_ch ();

    group_timed_light_off_timer_unit #(
        .GROUPS (GROUPS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (item_ch),
        .out_ch  (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // timer state as predicted
    mode_t               grp_mode    [GROUPS];
    logic [DELAY_W-1:0]  grp_delay   [GROUPS];
    logic [REPEAT_W-1:0] grp_repeat  [GROUPS];
    logic                grp_inhibit [GROUPS];
    logic [REPEAT_W-1:0] cfg_repeat_period;
    logic [MASK_W-1:0]   cfg_operative;

    light_cmd_t   cmd_q[$];
    light_order_t light_order_q[$];
    light_cmd_t   cur_cmd;

    int send_idle_pct;
    int recv_idle_pct;
    logic rx_hold;
    int n_accepted;
    int n_results;
    int n_off_results;
    int n_on_results;
    int err_count;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic light_order_t predict_light_orders(input light_cmd_t c);
        light_order_t r;
        logic fire;
        r = '0;
        case (c.op)
            OP_START:
                for (int g = 0; g < GROUPS; g++)
                begin
                    if (c.group_mask[g] && grp_mode[g] != MODE_OFF)
                    begin
                        if (c.regulator_active_mask[g])
                            r.refresh_mask[g] = 1'b1;
                        r.on_mask[g] = 1'b1;
                        grp_delay[g] = c.delay_value;
                        grp_inhibit[g] = 1'b0;
                        grp_mode[g] = MODE_RUN;
                    end
                end
            OP_TICK:
                for (int g = 0; g < GROUPS; g++)
                begin
                    fire = 1'b0;
                    if (grp_mode[g] == MODE_RUN)
                    begin
                        if (grp_delay[g] != '0)
                            grp_delay[g] = grp_delay[g] - 1'b1;
                        else
                        begin
                            grp_mode[g] = MODE_STOP;
                            fire = !grp_inhibit[g];
                        end
                    end
                    else if (grp_mode[g] == MODE_STOP)
                    begin
                        if (grp_repeat[g] != '0)
                            grp_repeat[g] = grp_repeat[g] - 1'b1;
                        else
                        begin
                            fire = !grp_inhibit[g];
                            grp_repeat[g] = cfg_repeat_period;
                        end
                    end
                    if (fire)
                    begin
                        if (c.regulator_active_mask[g])
                            r.refresh_mask[g] = 1'b1;
                        if (!c.presence_mask[g])
                            r.off_mask[g] = 1'b1;
                    end
                end
            OP_INHIBIT:
                grp_inhibit[c.group_index] = 1'b1;
            OP_RELOAD:
                grp_repeat[c.group_index] = cfg_repeat_period;
            OP_INIT:
                for (int g = 0; g < GROUPS; g++)
                begin
                    grp_mode[g] = cfg_operative[g] ? MODE_RUN : MODE_OFF;
                    grp_delay[g] = '0;
                    grp_repeat[g] = '0;
                    grp_inhibit[g] = 1'b0;
                end
            default:
                ;
        endcase
        r.query_mode = grp_mode[c.group_index];
        r.query_delay = grp_delay[c.group_index];
        r.query_repeat = grp_repeat[c.group_index];
        r.query_inhibited = grp_inhibit[c.group_index];
        return r;
    endfunction

    function automatic void queue_cmd(input logic [OP_W-1:0] op,
                                      input logic [MASK_W-1:0] mask,
                                      input logic [INDEX_W-1:0] gi,
                                      input logic [DELAY_W-1:0] dly,
                                      input logic [MASK_W-1:0] presence,
                                      input logic [MASK_W-1:0] regulator);
        light_cmd_t c;
        c.op = op;
        c.group_mask = mask;
        c.group_index = gi;
        c.delay_value = dly;
        c.presence_mask = presence;
        c.regulator_active_mask = regulator;
        cmd_q.push_back(c);
    endfunction

    function automatic void queue_random_cmd();
        int pick;
        logic [OP_W-1:0] op;
        logic [DELAY_W-1:0] dly;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            op = OP_TICK;
        else if (pick < 70)
            op = OP_START;
        else if (pick < 78)
            op = OP_INHIBIT;
        else if (pick < 87)
            op = OP_RELOAD;
        else if (pick < 92)
            op = OP_INIT;
        else
            op = OP_OFF_OR_SPARE();
        if ($urandom_range(0, 9) == 0)
            dly = DELAY_W'($urandom);
        else
            dly = DELAY_W'($urandom_range(0, 6));
        queue_cmd(op, MASK_W'($urandom), INDEX_W'($urandom_range(0, GROUPS - 1)), dly,
                  MASK_W'($urandom & $urandom), MASK_W'($urandom));
    endfunction

    function automatic logic [OP_W-1:0] OP_OFF_OR_SPARE();
        return OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
    endfunction

    task automatic cfg_write(input logic idx, input logic [DATA_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_REPEAT_PERIOD)
            cfg_repeat_period = value[REPEAT_W-1:0];
        else
            cfg_operative = value[MASK_W-1:0];
    endtask

    task automatic wait_drained();
        while (cmd_q.size() != 0 || item_ch.valid || light_order_q.size() != 0)
            @(posedge clk);
        repeat (GROUPS + 4) @(posedge clk);
    endtask

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
            item_ch.valid <= 1'b0;
        else if (!item_ch.valid || item_ch.ready)
        begin
            if (item_ch.valid)
            begin
                light_order_q.push_back(predict_light_orders(cur_cmd));
                n_accepted++;
            end
            if (cmd_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                cur_cmd = cmd_q.pop_front();
                item_ch.valid <= 1'b1;
                item_ch.op <= cur_cmd.op;
                item_ch.group_mask <= cur_cmd.group_mask;
                item_ch.group_index <= cur_cmd.group_index;
                item_ch.delay_value <= cur_cmd.delay_value;
                item_ch.presence_mask <= cur_cmd.presence_mask;
                item_ch.regulator_active_mask <= cur_cmd.regulator_active_mask;
            end
            else
                item_ch.valid <= 1'b0;
        end
    end

    // receiver
    always @(posedge clk)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
            res_ch.ready <= !rx_hold && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        light_order_t got;
        light_order_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got.on_mask = res_ch.on_mask;
            got.off_mask = res_ch.off_mask;
            got.refresh_mask = res_ch.refresh_mask;
            got.query_mode = res_ch.query_mode;
            got.query_delay = res_ch.query_delay;
            got.query_repeat = res_ch.query_repeat;
            got.query_inhibited = res_ch.query_inhibited;
            n_results++;
            if (got.on_mask != '0)
                n_on_results++;
            if (got.off_mask != '0)
                n_off_results++;
            if (light_order_q.size() == 0)
            begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("%0t: result transaction with none outstanding", $realtime);
            end
            else
            begin
                want = light_order_q.pop_front();
                if (got !== want)
                begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                    begin
                        $display("%0t: #%0d exp on %h off %h ref %h md %0d dly %h rep %h inh %b",
                                 $realtime, n_results, want.on_mask, want.off_mask,
                                 want.refresh_mask, want.query_mode, want.query_delay,
                                 want.query_repeat, want.query_inhibited);
                        $display("%0t: #%0d got on %h off %h ref %h md %0d dly %h rep %h inh %b",
                                 $realtime, n_results, got.on_mask, got.off_mask,
                                 got.refresh_mask, got.query_mode, got.query_delay,
                                 got.query_repeat, got.query_inhibited);
                    end
                end
            end
        end
    end

    // long receiver hold-off while the sender keeps offering
    initial
    begin
        rx_hold = 1'b0;
        wait (n_accepted >= 300);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    initial
    begin
        #4000000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        item_ch.valid = 1'b0;
        item_ch.op = OP_TICK;
        item_ch.group_mask = '0;
        item_ch.group_index = '0;
        item_ch.delay_value = '0;
        item_ch.presence_mask = '0;
        item_ch.regulator_active_mask = '0;
        res_ch.ready = 1'b0;
        send_idle_pct = 21;
        recv_idle_pct = 61;
        n_accepted = 0;
        n_results = 0;
        n_off_results = 0;
        n_on_results = 0;
        err_count = 0;
        cfg_repeat_period = REPEAT_PERIOD_RST;
        cfg_operative = OPERATIVE_RST;
        for (int g = 0; g < GROUPS; g++)
        begin
            grp_mode[g] = MODE_OFF;
            grp_delay[g] = '0;
            grp_repeat[g] = '0;
            grp_inhibit[g] = 1'b0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset values: nothing is operative yet
        queue_cmd(OP_TICK, 16'hFFFF, 4'd0, 16'd0, 16'h0000, 16'hFFFF);
        queue_cmd(OP_START, 16'hFFFF, 4'd15, 16'hFFFF, 16'h0000, 16'hFFFF);
        queue_cmd(OP_INIT, 16'h0000, 4'd7, 16'd0, 16'h0000, 16'h0000);
        wait_drained();

        // all groups operative, shortest repeat period
        cfg_write(REG_OPERATIVE, 32'h0000_FFFF);
        cfg_write(REG_REPEAT_PERIOD, 32'h0000_0000);
        queue_cmd(OP_INIT, 16'h0000, 4'd0, 16'd0, 16'h0000, 16'h0000);
        queue_cmd(OP_START, 16'hFFFF, 4'd1, 16'd0, 16'h0000, 16'hAAAA);
        queue_cmd(OP_TICK, 16'h0000, 4'd4, 16'd0, 16'h00F0, 16'hFFFF);
        queue_cmd(OP_TICK, 16'h0000, 4'd2, 16'd0, 16'h0000, 16'h0000);
        queue_cmd(OP_INHIBIT, 16'h0000, 4'd3, 16'd0, 16'h0000, 16'h0000);
        queue_cmd(OP_TICK, 16'h0000, 4'd3, 16'd0, 16'h0000, 16'hFFFF);
        queue_cmd(OP_RELOAD, 16'h0000, 4'd5, 16'd0, 16'h0000, 16'h0000);
        queue_cmd(OP_START, 16'h0001, 4'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_cmd(OP_TICK, 16'h0000, 4'd0, 16'd0, 16'hFFFF, 16'h0000);
        queue_cmd(OP_SPARE_FIRST, 16'hFFFF, 4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_cmd(OP_SPARE_MID, 16'h5555, 4'd8, 16'h5555, 16'h5555, 16'h5555);
        queue_cmd(OP_SPARE_LAST, 16'hAAAA, 4'd0, 16'hAAAA, 16'hAAAA, 16'hAAAA);
        queue_cmd(OP_START, 16'h8000, 4'd15, 16'd1, 16'h0000, 16'h0000);
        wait_drained();

        // sparse operative set, longest repeat period
        cfg_write(REG_REPEAT_PERIOD, 32'h0000_00FF);
        cfg_write(REG_OPERATIVE, 32'h0000_5A5A);
        queue_cmd(OP_INIT, 16'h0000, 4'd1, 16'd0, 16'h0000, 16'h0000);
        queue_cmd(OP_TICK, 16'h0000, 4'd1, 16'd0, 16'hFFFF, 16'hFFFF);
        queue_cmd(OP_TICK, 16'h0000, 4'd1, 16'd0, 16'h0000, 16'hFFFF);
        queue_cmd(OP_TICK, 16'h0000, 4'd1, 16'd0, 16'h0000, 16'h0000);
        queue_cmd(OP_RELOAD, 16'h0000, 4'd1, 16'd0, 16'h0000, 16'h0000);
        queue_cmd(OP_START, 16'hFFFF, 4'd0, 16'd2, 16'h0000, 16'h5555);
        queue_cmd(OP_INHIBIT, 16'h0000, 4'd4, 16'd0, 16'h0000, 16'h0000);
        queue_cmd(OP_TICK, 16'h0000, 4'd4, 16'd0, 16'h0000, 16'hFFFF);
        queue_cmd(OP_START, 16'h0010, 4'd4, 16'd0, 16'h0000, 16'hFFFF);
        wait_drained();

        for (int phase = 0; phase < 3; phase++)
        begin
            if (phase == 0)
            begin
                send_idle_pct = 21;
                recv_idle_pct = 61;
            end
            else if (phase == 1)
            begin
                send_idle_pct = 61;
                recv_idle_pct = 21;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int set = 0; set < 4; set++)
            begin
                case (set)
                    0: cfg_write(REG_REPEAT_PERIOD, 32'h0000_0000);
                    1: cfg_write(REG_REPEAT_PERIOD, 32'h0000_00FF);
                    2: cfg_write(REG_REPEAT_PERIOD, DATA_W'($urandom_range(1, 4)));
                    default: cfg_write(REG_REPEAT_PERIOD, DATA_W'($urandom_range(0, 8)));
                endcase
                if (set == 0)
                    cfg_write(REG_OPERATIVE, 32'h0000_FFFF);
                else
                    cfg_write(REG_OPERATIVE, {16'h0000, MASK_W'($urandom) | 16'h0101});
                queue_cmd(OP_INIT, 16'h0000, INDEX_W'($urandom_range(0, GROUPS - 1)), 16'd0,
                          16'h0000, 16'h0000);
                for (int k = 0; k < RANDOM_PER_SET; k++)
                    queue_random_cmd();
                wait_drained();
            end
        end

        $display("covered %0d command transactions and %0d results,", n_accepted, n_results);
        $display("%0d with on orders and %0d with off orders, three idling mixes,",
                 n_on_results, n_off_results);
        $display("repeat periods from 0 to 255, one long receiver hold-off");
        if (err_count == 0 && light_order_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
